@@ hw/rtl/spi_pkg.sv @@
// ----------------------------------------------------------------------------
// spi_pkg
// shared types and constants of the segment / plane intersection block
// ----------------------------------------------------------------------------
`default_nettype none

package spi_pkg;

   localparam int DATA_W = 32;
   localparam int TOL_W  = 17;
   localparam int FRAC_W = 16;
   localparam int DOT_W  = 35;              // rounded dot product, q19.16
   localparam int NUM_W  = 36;              // offset minus dot, wide
   localparam int REM_W  = NUM_W + FRAC_W;  // dividend magnitude
   localparam int QUO_W  = 18;              // quotient bits kept, range is below 2^18
   localparam int CSR_W  = 3;

   localparam logic signed [DATA_W-1:0] NORMAL_Z_RESET = 32'sh4000_0000;
   localparam logic [TOL_W-1:0]         TOL_RESET      = 17'd66;

   typedef enum logic [CSR_W-1:0] {
      CSR_NORMAL_X     = 3'd0,
      CSR_NORMAL_Y     = 3'd1,
      CSR_NORMAL_Z     = 3'd2,
      CSR_PLANE_OFFSET = 3'd3,
      CSR_TOLERANCE    = 3'd4
   } spi_csr_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] start_x;
      logic signed [DATA_W-1:0] start_y;
      logic signed [DATA_W-1:0] start_z;
      logic signed [DATA_W-1:0] dir_x;
      logic signed [DATA_W-1:0] dir_y;
      logic signed [DATA_W-1:0] dir_z;
   } spi_req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] hit_param;
      logic signed [DATA_W-1:0] start_distance;
      logic                     start_behind;
   } spi_rsp_type;

   // status that rides along the divider cells
   typedef struct packed {
      logic                     qneg;
      logic                     ok;
      logic [TOL_W-1:0]         tol;
      logic signed [DATA_W-1:0] dist_sat;
      logic                     behind;
   } spi_side_type;

endpackage

`default_nettype wire

@@ hw/rtl/spi_dot.sv @@
// ----------------------------------------------------------------------------
// spi_dot
// three-term q2.30 x q16.16 dot product rounded to q19.16, two stages
// ----------------------------------------------------------------------------
`default_nettype none

module spi_dot
   import spi_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [DATA_W-1:0] a0,
   input  wire logic signed [DATA_W-1:0] a1,
   input  wire logic signed [DATA_W-1:0] a2,
   input  wire logic signed [DATA_W-1:0] b0,
   input  wire logic signed [DATA_W-1:0] b1,
   input  wire logic signed [DATA_W-1:0] b2,
   output logic signed [DOT_W-1:0]       dot
);

   logic signed [2*DATA_W-1:0] prod0_ff, prod1_ff, prod2_ff;
   logic signed [2*DATA_W:0]   sum;
   logic signed [DOT_W-1:0]    dot_ff;

   always_ff @(posedge clock) begin
      prod0_ff <= 64'(a0) * 64'(b0);
      prod1_ff <= 64'(a1) * 64'(b1);
      prod2_ff <= 64'(a2) * 64'(b2);
   end

   // exact sum, add half lsb, floor
   assign sum = 65'(prod0_ff) + 65'(prod1_ff) + 65'(prod2_ff) + 65'sd536870912;

   always_ff @(posedge clock) begin
      dot_ff <= sum[2*DATA_W:30];
   end

   assign dot = dot_ff;

endmodule

`default_nettype wire

@@ hw/rtl/spi_div_cell.sv @@
// ----------------------------------------------------------------------------
// spi_div_cell
// one restoring division step, one quotient bit, registered
// ----------------------------------------------------------------------------
`default_nettype none

module spi_div_cell
   import spi_pkg::*;
#(
   parameter int SHIFT = 0
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [REM_W-1:0]     in_rem,
   input  wire logic [DOT_W-1:0]     in_den,
   input  wire logic [QUO_W-1:0]     in_quo,
   input  wire spi_side_type         in_side,
   output logic                      out_valid,
   output logic [REM_W-1:0]          out_rem,
   output logic [DOT_W-1:0]          out_den,
   output logic [QUO_W-1:0]          out_quo,
   output spi_side_type              out_side
);

   logic [REM_W-1:0] den_sh;
   logic [REM_W:0]   diff;
   logic             valid_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DOT_W-1:0] den_ff;
   logic [QUO_W-1:0] quo_ff, quo_in;
   spi_side_type     side_ff;

   assign den_sh = REM_W'(in_den) << SHIFT;
   assign diff   = {1'b0, in_rem} - {1'b0, den_sh};

   always_comb begin
      if (!diff[REM_W]) begin
         rem_in = diff[REM_W-1:0];
         quo_in = {in_quo[QUO_W-2:0], 1'b1};
      end else begin
         rem_in = in_rem;
         quo_in = {in_quo[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= in_den;
      quo_ff  <= quo_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

@@ hw/rtl/segment_plane_intersection_top.sv @@
// ----------------------------------------------------------------------------
// segment_plane_intersection_top
// segment against configured plane: start distance, side and hit parameter
// ----------------------------------------------------------------------------
// a segment is taken at every clock edge with start high and busy low; busy
// is only high right after reset, so one segment per cycle streams through.
// every segment gives exactly one result, shown for one cycle
// with rsp_strobe; the receiver cannot stall, so it must take each result in
// that cycle. the pipeline is made of two multiply/round stages for the dot
// products, two stages for distance and operand prep, a row of 18 division
// cells (one quotient bit each) and the output register. configuration may
// only be written while no segment is in flight.
`default_nettype none

module segment_plane_intersection_top
   import spi_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // transaction input
   input  wire logic              start,
   output logic                   busy,
   input  wire spi_req_type       req_data,
   // results
   output logic                   rsp_strobe,
   output spi_rsp_type            rsp_data,
   // register writes
   input  wire logic              csr_we,
   input  wire logic [CSR_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic signed [DATA_W-1:0] normal_x_ff, normal_y_ff, normal_z_ff, plane_offset_ff;
   logic [TOL_W-1:0]         tolerance_ff;
   logic                     busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_x_ff     <= '0;
         normal_y_ff     <= '0;
         normal_z_ff     <= NORMAL_Z_RESET;
         plane_offset_ff <= '0;
         tolerance_ff    <= TOL_RESET;
         busy_ff         <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_NORMAL_X:     normal_x_ff     <= csr_wdata;
               CSR_NORMAL_Y:     normal_y_ff     <= csr_wdata;
               CSR_NORMAL_Z:     normal_z_ff     <= csr_wdata;
               CSR_PLANE_OFFSET: plane_offset_ff <= csr_wdata;
               CSR_TOLERANCE:    tolerance_ff    <= csr_wdata[TOL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign busy = busy_ff;

   // valid bits for the dot product and operand prep stages
   logic accept;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // dot(n, s) and dot(n, v)
   logic signed [DOT_W-1:0] ds, den;

   spi_dot u_dot_start (
      .clock (clock),
      .a0    (normal_x_ff), .a1 (normal_y_ff), .a2 (normal_z_ff),
      .b0    (req_data.start_x), .b1 (req_data.start_y), .b2 (req_data.start_z),
      .dot   (ds)
   );

   spi_dot u_dot_dir (
      .clock (clock),
      .a0    (normal_x_ff), .a1 (normal_y_ff), .a2 (normal_z_ff),
      .b0    (req_data.dir_x), .b1 (req_data.dir_y), .b2 (req_data.dir_z),
      .dot   (den)
   );

   // distance, numerator and parallel test
   logic signed [NUM_W-1:0] off_ext, ds_ext, num_in, dist_wide;
   logic signed [DATA_W-1:0] dist_sat_in;
   logic [DOT_W-1:0]         den_mag_in;
   logic                     den_ok_in;

   logic signed [NUM_W-1:0]  num_ff;
   logic signed [DATA_W-1:0] dist_sat_ff;
   logic                     behind_ff, den_ok_ff, den_neg_ff;
   logic [DOT_W-1:0]         den_mag_ff;

   assign off_ext   = NUM_W'(plane_offset_ff);
   assign ds_ext    = NUM_W'(ds);
   assign num_in    = off_ext - ds_ext;
   assign dist_wide = ds_ext - off_ext;

   always_comb begin
      if (dist_wide > 36'sd2147483647) begin
         dist_sat_in = 32'sh7fff_ffff;
      end else if (dist_wide < -36'sd2147483648) begin
         dist_sat_in = 32'sh8000_0000;
      end else begin
         dist_sat_in = dist_wide[DATA_W-1:0];
      end
   end

   // the most negative value negates to its own pattern, read unsigned it is right
   assign den_mag_in = den[DOT_W-1] ? DOT_W'(-den) : DOT_W'(den);
   assign den_ok_in  = (den != '0) && (den_mag_in >= DOT_W'(tolerance_ff));

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      dist_sat_ff <= dist_sat_in;
      behind_ff   <= dist_wide[NUM_W-1];
      den_ok_ff   <= den_ok_in;
      den_neg_ff  <= den[DOT_W-1];
      den_mag_ff  <= den_mag_in;
   end

   // operand magnitudes, quotient sign and range precheck
   logic [NUM_W-1:0] num_mag;
   logic             ovf;
   spi_side_type     side_in;
   logic [REM_W-1:0] rem0_ff;
   logic [DOT_W-1:0] den0_ff;
   spi_side_type     side0_ff;

   assign num_mag = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   // quotient of 2^18 or more is far outside the accepted range
   assign ovf     = {1'b0, num_mag} >= {den_mag_ff, 2'b00};

   always_comb begin
      side_in.qneg     = num_ff[NUM_W-1] ^ den_neg_ff;
      side_in.ok       = den_ok_ff && !ovf;
      side_in.tol      = tolerance_ff;
      side_in.dist_sat = dist_sat_ff;
      side_in.behind   = behind_ff;
   end

   always_ff @(posedge clock) begin
      rem0_ff  <= {num_mag, {FRAC_W{1'b0}}};
      den0_ff  <= den_mag_ff;
      side0_ff <= side_in;
   end

   // row of division cells, most significant quotient bit first
   logic             cv   [QUO_W+1];
   logic [REM_W-1:0] crem [QUO_W+1];
   logic [DOT_W-1:0] cden [QUO_W+1];
   logic [QUO_W-1:0] cquo [QUO_W+1];
   spi_side_type     cside[QUO_W+1];

   assign cv[0]    = v4_ff;
   assign crem[0]  = rem0_ff;
   assign cden[0]  = den0_ff;
   assign cquo[0]  = '0;
   assign cside[0] = side0_ff;

   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      spi_div_cell #(
         .SHIFT (QUO_W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[k]),
         .in_rem    (crem[k]),
         .in_den    (cden[k]),
         .in_quo    (cquo[k]),
         .in_side   (cside[k]),
         .out_valid (cv[k+1]),
         .out_rem   (crem[k+1]),
         .out_den   (cden[k+1]),
         .out_quo   (cquo[k+1]),
         .out_side  (cside[k+1])
      );
   end

   // range test and result register
   logic [QUO_W-1:0]         qmag;
   spi_side_type             fside;
   logic                     in_range, hit;
   logic signed [DATA_W-1:0] qpos;
   spi_rsp_type              rsp_in, rsp_ff;
   logic                     strobe_ff;

   assign qmag  = cquo[QUO_W];
   assign fside = cside[QUO_W];
   assign qpos  = DATA_W'(qmag);

   always_comb begin
      if (fside.qneg) begin
         in_range = qmag <= QUO_W'(fside.tol);
      end else begin
         in_range = qmag <= (QUO_W'(fside.tol) + 18'd65536);
      end
      hit                   = fside.ok && in_range;
      rsp_in.hit            = hit;
      rsp_in.hit_param      = hit ? (fside.qneg ? -qpos : qpos) : '0;
      rsp_in.start_distance = fside.dist_sat;
      rsp_in.start_behind   = fside.behind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cv[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // crem of the last cell is the remainder, not needed
   logic unused_rem;
   assign unused_rem = ^crem[QUO_W] ^ ^cden[QUO_W];

endmodule

`default_nettype wire
